// File: rtl/vcfp_pkg.sv
// Shared constants and types for the velocity command frame parser.
`default_nettype none
package vcfp_pkg;

    localparam logic [7:0] HdrByte   = 8'h7B;
    localparam logic [7:0] TailByte  = 8'h7D;
    localparam int         FrameLen  = 11;
    localparam int         CheckPos  = 9;
    localparam logic [3:0] FrameLast = 4'(FrameLen - 1);
    localparam logic [3:0] CheckIdx  = 4'(CheckPos);

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_TAIL = 2'd1,
        STATUS_BAD_SUM  = 2'd2
    } frame_status_t;

endpackage
`default_nettype wire

// File: rtl/velocity_command_frame_parser.sv
// Top level: byte-wise command frame parser with header, tail and XOR checksum.
// Data path: an accepted beat sits in the input register; its result, if any, is registered
// from there into the output register, which raises out_valid.
// Throughput: one byte beat per cycle; the input register stalls only while a result
// waits in the output register and the next beat has been taken in.
// Reset: rst_n clears position, running XOR, held targets and both valid flags.
`default_nettype none
module velocity_command_frame_parser (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [7:0]                 rx_byte,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output vcfp_pkg::frame_status_t         frame_status,
    output logic signed [15:0]              x_speed,
    output logic signed [15:0]              y_speed,
    output logic signed [15:0]              z_speed
);
    import vcfp_pkg::*;

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;

    logic [3:0]    pos_reg,  pos_next;
    logic [7:0]    xor_reg,  xor_next;
    logic [7:0]    spd_reg [6];
    logic [7:0]    chk_reg;
    logic [15:0]   tx_reg, ty_reg, tz_reg;
    logic [15:0]   tx_next, ty_next, tz_next;

    logic          out_valid_reg;
    frame_status_t status_reg, status_next;

    logic          advance;
    logic          done;
    logic [3:0]    pos;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign pos      = (pos_reg > FrameLast) ? 4'd0 : pos_reg;

    always_comb
    begin
        pos_next    = pos;
        xor_next    = xor_reg;
        tx_next     = tx_reg;
        ty_next     = ty_reg;
        tz_next     = tz_reg;
        status_next = STATUS_OK;
        done        = 1'b0;
        if (pos == 4'd0 && in_byte_reg != HdrByte) begin
            pos_next = 4'd0;
        end else if (pos == FrameLast) begin
            done     = 1'b1;
            pos_next = 4'd0;
            xor_next = 8'd0;
            if (in_byte_reg != TailByte) begin
                status_next = STATUS_BAD_TAIL;
            end else if (xor_reg != chk_reg) begin
                status_next = STATUS_BAD_SUM;
            end else begin
                tx_next = {spd_reg[1], spd_reg[0]};
                ty_next = {spd_reg[3], spd_reg[2]};
                tz_next = {spd_reg[5], spd_reg[4]};
            end
        end else begin
            pos_next = pos + 4'd1;
            if (pos < CheckIdx) begin
                xor_next = xor_reg ^ in_byte_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= 4'd0;
            xor_reg       <= 8'd0;
            tx_reg        <= 16'd0;
            ty_reg        <= 16'd0;
            tz_reg        <= 16'd0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            if (advance && done) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                pos_reg <= pos_next;
                xor_reg <= xor_next;
                tx_reg  <= tx_next;
                ty_reg  <= ty_next;
                tz_reg  <= tz_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            in_byte_reg <= rx_byte;
        end
        if (advance) begin
            if (pos >= 4'd3 && pos <= 4'd8) begin
                spd_reg[3'(pos - 4'd3)] <= in_byte_reg;
            end
            if (pos == CheckIdx) begin
                chk_reg <= in_byte_reg;
            end
            if (done) begin
                status_reg <= status_next;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_status = status_reg;
    assign x_speed      = tx_reg;
    assign y_speed      = ty_reg;
    assign z_speed      = tz_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= FrameLast)
        else $error("frame position out of range");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("beat taken while result stalled");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pos_reg) == FrameLast)
        else $error("result without a closing beat");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg == STATUS_OK || status_reg == STATUS_BAD_TAIL
                           || status_reg == STATUS_BAD_SUM))
        else $error("invalid status on result");

endmodule
`default_nettype wire
